// ===== rtl/core/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types, token kinds and keyword table of the schema text tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

    localparam int KwCount   = 23;
    localparam int KwMaxLen  = 8;

    localparam logic [5:0] KIND_IDENT   = 6'd23;
    localparam logic [5:0] KIND_INTEGER = 6'd24;
    localparam logic [5:0] KIND_PUNCT   = 6'd25;
    localparam logic [5:0] KIND_EOF     = 6'd34;
    localparam logic [5:0] KIND_NONE    = 6'd0;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_OVERFLOW = 3'd1;
    localparam logic [2:0] ERR_NO_SPACE = 3'd2;
    localparam logic [2:0] ERR_CR       = 3'd3;
    localparam logic [2:0] ERR_BAD_BYTE = 3'd4;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_US   = 8'h5f;

    localparam int TokBits  = 209;
    localparam int DataBits = 216;

    // one result item; keyword text in t_kw is right aligned, last char in the low byte
    typedef struct packed {
        logic [7:0]  bad_byte;
        logic [63:0] int_value;
        logic [31:0] column_no;
        logic [31:0] line_no;
        logic [31:0] token_length;
        logic [31:0] start_offset;
        logic [2:0]  error_code;
        logic [5:0]  kind;
    } t_tok;

    typedef struct packed {
        logic [63:0] text;
        logic [3:0]  len;
    } t_kw;

    localparam t_kw KW_TABLE [KwCount] = '{
        '{64'("type"), 4'd4}, '{64'("uint"), 4'd4}, '{64'("u8"), 4'd2},
        '{64'("u16"), 4'd3}, '{64'("u32"), 4'd3}, '{64'("u64"), 4'd3},
        '{64'("int"), 4'd3}, '{64'("i8"), 4'd2}, '{64'("i16"), 4'd3},
        '{64'("i32"), 4'd3}, '{64'("i64"), 4'd3}, '{64'("f32"), 4'd3},
        '{64'("f64"), 4'd3}, '{64'("bool"), 4'd4}, '{64'("str"), 4'd3},
        '{64'("data"), 4'd4}, '{64'("void"), 4'd4}, '{64'("enum"), 4'd4},
        '{64'("optional"), 4'd8}, '{64'("list"), 4'd4}, '{64'("map"), 4'd3},
        '{64'("union"), 4'd5}, '{64'("struct"), 4'd6}
    };

    localparam logic [7:0] PUNCT_TABLE [9] = '{
        8'h7b, 8'h7d, 8'h3c, 8'h3e, 8'h5b, 8'h5d, 8'h3a, 8'h7c, 8'h3d
    };

    // chars: char i in byte i; cnt clipped, 9 means too long for any keyword
    function automatic logic [5:0] kw_lookup(logic [63:0] chars, logic [3:0] cnt);
        logic [5:0] kind;
        logic       hit;
        kind = KIND_IDENT;
        for (int k = KwCount - 1; k >= 0; k--) begin
            hit = (cnt == KW_TABLE[k].len);
            for (int i = 0; i < KwMaxLen; i++) begin
                if (i < int'(KW_TABLE[k].len)) begin
                    hit = hit && (chars[i*8 +: 8] ==
                        KW_TABLE[k].text[(int'(KW_TABLE[k].len) - 1 - i)*8 +: 8]);
                end
            end
            if (hit) begin
                kind = 6'(k);
            end
        end
        return kind;
    endfunction

    function automatic logic char_letter(logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
    endfunction

    function automatic logic char_num(logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sst_scan.sv =====
// ----------------------------------------------------------------------------
// sst_scan
// Scanner state and per-byte token logic; gives up to two results per request.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_scan #(
    parameter int POS_BITS      = 32,
    parameter int KEYWORD_CHARS = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_take,
    input  wire logic           i_op,
    input  wire logic [7:0]     i_byte,
    output sst_pkg::t_tok       o_res0,
    output sst_pkg::t_tok       o_res1,
    output logic                o_last0,
    output logic [1:0]          o_count
);

    localparam int CW   = $clog2(KEYWORD_CHARS + 2);
    localparam int IDXW = $clog2(KEYWORD_CHARS);

    typedef enum logic [2:0] {
        M_IDLE, M_COMMENT, M_IDENT, M_INTEGER, M_ERROR
    } t_mode;

    t_mode                r_mode, n_mode;
    logic [POS_BITS-1:0]  r_pos, n_pos, r_line, n_line, r_col, n_col;
    logic [POS_BITS-1:0]  r_tpos, n_tpos, r_tline, n_tline, r_tcol, n_tcol;
    logic [7:0]           r_chars [KEYWORD_CHARS];
    logic [7:0]           n_chars [KEYWORD_CHARS];
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [63:0]          r_acc, n_acc;

    // clip a counter to the 32-bit result field
    function automatic logic [31:0] out32(logic [POS_BITS-1:0] v);
        logic [POS_BITS+31:0] ext;
        ext = {32'b0, v};
        return (|ext[POS_BITS+31:32]) ? 32'hffff_ffff : ext[31:0];
    endfunction

    function automatic logic [POS_BITS-1:0] sat_inc(logic [POS_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic sst_pkg::t_tok mk(logic [5:0] kind, logic [2:0] err,
        logic [POS_BITS-1:0] off, logic [POS_BITS-1:0] len,
        logic [POS_BITS-1:0] line, logic [POS_BITS-1:0] col,
        logic [63:0] val, logic [7:0] bad);
        sst_pkg::t_tok t;
        t.kind = kind;
        t.error_code = err;
        t.start_offset = out32(off);
        t.token_length = out32(len);
        t.line_no = out32(line);
        t.column_no = out32(col);
        t.int_value = val;
        t.bad_byte = bad;
        return t;
    endfunction

    logic [63:0]          kw_chars;
    logic [3:0]           kw_cnt;
    logic [5:0]           ident_kind;
    logic [67:0]          acc_next;
    logic [POS_BITS-1:0]  tok_len;
    sst_pkg::t_tok        res [2];
    logic [1:0]           n_res;
    logic                 adv, bnd, fresh, punct_hit;
    logic [5:0]           punct_kind;

    // keyword match over the first buffered chars
    always_comb begin
        for (int i = 0; i < sst_pkg::KwMaxLen; i++) begin
            kw_chars[i*8 +: 8] = r_chars[i];
        end
        kw_cnt = (r_cnt > CW'(sst_pkg::KwMaxLen)) ? 4'd9 : 4'(r_cnt);
        ident_kind = sst_pkg::kw_lookup(kw_chars, kw_cnt);
        acc_next = {1'b0, r_acc, 3'b0} + {3'b0, r_acc, 1'b0} + {64'b0, i_byte[3:0]};
        tok_len = r_pos - r_tpos;
        punct_hit = 1'b0;
        punct_kind = sst_pkg::KIND_PUNCT;
        for (int k = 0; k < 9; k++) begin
            if (i_byte == sst_pkg::PUNCT_TABLE[k]) begin
                punct_hit = 1'b1;
                punct_kind = sst_pkg::KIND_PUNCT + 6'(k);
            end
        end
    end

    // next state and results
    always_comb begin
        n_mode = r_mode; n_pos = r_pos; n_line = r_line; n_col = r_col;
        n_tpos = r_tpos; n_tline = r_tline; n_tcol = r_tcol;
        n_chars = r_chars; n_cnt = r_cnt; n_acc = r_acc;
        res[0] = '0; res[1] = '0; n_res = 2'd0;
        adv = 1'b0; bnd = 1'b0; fresh = 1'b0;
        if (i_op == sst_pkg::OP_END) begin
            fresh = 1'b1;
            if (r_mode != M_ERROR) begin
                if (r_mode == M_IDENT) begin
                    res[0] = mk(ident_kind, sst_pkg::ERR_NONE, r_tpos, tok_len,
                                r_tline, r_tcol, 64'd0, 8'd0);
                    n_res = 2'd1;
                end else if (r_mode == M_INTEGER) begin
                    res[0] = mk(sst_pkg::KIND_INTEGER, sst_pkg::ERR_NONE, r_tpos,
                                tok_len, r_tline, r_tcol, r_acc, 8'd0);
                    n_res = 2'd1;
                end
                res[n_res[0]] = mk(sst_pkg::KIND_EOF, sst_pkg::ERR_NONE, r_pos,
                                   '0, r_line, r_col, 64'd0, 8'd0);
                n_res = n_res + 2'd1;
            end
        end else begin
            case (r_mode)
                M_COMMENT: begin
                    if (i_byte == sst_pkg::CH_LF) begin
                        n_mode = M_IDLE;
                    end
                    adv = 1'b1;
                end
                M_IDENT: begin
                    if (sst_pkg::char_letter(i_byte) || sst_pkg::char_num(i_byte) ||
                        i_byte == sst_pkg::CH_US) begin
                        if (r_cnt < CW'(KEYWORD_CHARS)) begin
                            n_chars[r_cnt[IDXW-1:0]] = i_byte;
                        end
                        if (r_cnt <= CW'(KEYWORD_CHARS)) begin
                            n_cnt = r_cnt + 1'b1;
                        end
                        adv = 1'b1;
                    end else begin
                        res[0] = mk(ident_kind, sst_pkg::ERR_NONE, r_tpos, tok_len,
                                    r_tline, r_tcol, 64'd0, 8'd0);
                        n_res = 2'd1;
                        bnd = 1'b1;
                    end
                end
                M_INTEGER: begin
                    if (sst_pkg::char_num(i_byte)) begin
                        if (|acc_next[67:64]) begin
                            n_mode = M_ERROR;
                            res[0] = mk(sst_pkg::KIND_NONE, sst_pkg::ERR_OVERFLOW,
                                        r_tpos, '0, r_tline, r_tcol, 64'd0, 8'd0);
                            n_res = 2'd1;
                        end else begin
                            n_acc = acc_next[63:0];
                            adv = 1'b1;
                        end
                    end else if (sst_pkg::char_letter(i_byte) ||
                                 i_byte == sst_pkg::CH_US) begin
                        n_mode = M_ERROR;
                        res[0] = mk(sst_pkg::KIND_NONE, sst_pkg::ERR_NO_SPACE, r_pos,
                                    '0, r_line, r_col, 64'd0, 8'd0);
                        n_res = 2'd1;
                    end else begin
                        res[0] = mk(sst_pkg::KIND_INTEGER, sst_pkg::ERR_NONE, r_tpos,
                                    tok_len, r_tline, r_tcol, r_acc, 8'd0);
                        n_res = 2'd1;
                        bnd = 1'b1;
                    end
                end
                M_ERROR: begin
                    n_mode = M_ERROR;
                end
                default: begin
                    bnd = 1'b1;
                end
            endcase
            // byte at a token boundary
            if (bnd) begin
                n_mode = M_IDLE;
                if (i_byte == sst_pkg::CH_SP || i_byte == sst_pkg::CH_TAB ||
                    i_byte == sst_pkg::CH_LF) begin
                    adv = 1'b1;
                end else if (i_byte == sst_pkg::CH_HASH) begin
                    n_mode = M_COMMENT;
                    adv = 1'b1;
                end else if (sst_pkg::char_letter(i_byte)) begin
                    n_tpos = r_pos; n_tline = r_line; n_tcol = r_col;
                    n_chars[0] = i_byte;
                    n_cnt = CW'(1);
                    n_mode = M_IDENT;
                    adv = 1'b1;
                end else if (sst_pkg::char_num(i_byte)) begin
                    n_tpos = r_pos; n_tline = r_line; n_tcol = r_col;
                    n_acc = {60'b0, i_byte[3:0]};
                    n_mode = M_INTEGER;
                    adv = 1'b1;
                end else if (punct_hit) begin
                    res[n_res[0]] = mk(punct_kind, sst_pkg::ERR_NONE, r_pos,
                                       POS_BITS'(1), r_line, r_col, 64'd0, 8'd0);
                    n_res = n_res + 2'd1;
                    adv = 1'b1;
                end else begin
                    n_mode = M_ERROR;
                    res[n_res[0]] = mk(sst_pkg::KIND_NONE,
                        (i_byte == sst_pkg::CH_CR) ? sst_pkg::ERR_CR : sst_pkg::ERR_BAD_BYTE,
                        r_pos, '0, r_line, r_col, 64'd0, i_byte);
                    n_res = n_res + 2'd1;
                end
            end
        end
        // position, line and column move past the byte
        if (adv) begin
            n_pos = sat_inc(r_pos);
            if (i_byte == sst_pkg::CH_LF) begin
                n_line = sat_inc(r_line);
                n_col = POS_BITS'(1);
            end else begin
                n_col = sat_inc(r_col);
            end
        end
        if (fresh) begin
            n_mode = M_IDLE; n_pos = '0; n_line = POS_BITS'(1); n_col = POS_BITS'(1);
            n_tpos = '0; n_tline = POS_BITS'(1); n_tcol = POS_BITS'(1);
            n_cnt = '0; n_acc = '0;
        end
    end

    assign o_res0  = res[0];
    assign o_res1  = res[1];
    assign o_count = i_take ? n_res : 2'd0;
    assign o_last0 = (n_res == 2'd1);

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_pos <= '0; r_line <= POS_BITS'(1); r_col <= POS_BITS'(1);
            r_tpos <= '0; r_tline <= POS_BITS'(1); r_tcol <= POS_BITS'(1);
            r_cnt <= '0; r_acc <= '0;
        end else if (i_take) begin
            r_mode <= n_mode; r_pos <= n_pos; r_line <= n_line; r_col <= n_col;
            r_tpos <= n_tpos; r_tline <= n_tline; r_tcol <= n_tcol;
            r_cnt <= n_cnt; r_acc <= n_acc;
        end
    end

    // identifier chars, no reset
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_chars <= n_chars;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sst_fifo.sv =====
// ----------------------------------------------------------------------------
// sst_fifo
// Four-entry result queue; takes up to two results a cycle, gives one.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [1:0]     i_push,
    input  wire logic [sst_pkg::TokBits:0] i_d0,
    input  wire logic [sst_pkg::TokBits:0] i_d1,
    input  wire logic           i_pop,
    output logic [sst_pkg::TokBits:0] o_head,
    output logic                o_valid,
    output logic                o_room2
);

    logic [sst_pkg::TokBits:0] r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_count, n_count;
    logic       pop_ok;

    assign pop_ok  = i_pop && (r_count != 3'd0);
    assign n_count = r_count + {1'b0, i_push} - {2'b0, pop_ok};
    assign o_head  = r_mem[r_rp];
    assign o_valid = (r_count != 3'd0);
    assign o_room2 = (r_count <= 3'd2);

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_count <= '0;
        end else begin
            r_wp <= r_wp + i_push;
            r_rp <= r_rp + {1'b0, pop_ok};
            r_count <= n_count;
        end
    end

    // entries
    always_ff @(posedge i_clk) begin
        if (i_push != 2'd0) begin
            r_mem[r_wp] <= i_d0;
        end
        if (i_push == 2'd2) begin
            r_mem[r_wp + 2'd1] <= i_d1;
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4) else $error("result queue overfilled");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count == $past(n_count))
        else $error("fill count out of step");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push != 2'd0) |-> (r_count + {1'b0, i_push} <= 3'd4 + {2'b0, pop_ok}))
        else $error("push without room");

endmodule

`default_nettype wire

// ===== rtl/core/schema_text_tokenizer.sv =====
// ----------------------------------------------------------------------------
// schema_text_tokenizer
// Turns a stream of source bytes into schema tokens with their locations.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                 tuser  tlast
//  s_axis    in   byte_in[7:0]          op     -
//  m_axis    out  token fields (216 b)  -      last_of_run
//
//  One request is taken per cycle while the four-entry result queue has room
//  for two results; each gives zero, one or two results.
//  Results leave the queue one per cycle while m_axis_tready is high, so
//  requests that give two results each cannot all be taken back to back.
//  A stalled output backs up the queue and then holds the input; synchronous
//  reset, active low, clears the scanner and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module schema_text_tokenizer #(
    parameter int POS_BITS      = 32,
    parameter int KEYWORD_CHARS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // byte_in
    input  wire logic        s_axis_tuser,   // op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // kind, error_code, start_offset, token_length, line_no, column_no,
    // int_value, bad_byte, zero pad
    output logic [sst_pkg::DataBits-1:0] m_axis_tdata,
    output logic             m_axis_tlast    // last_of_run
);

    logic                     take, last0, room2;
    logic [1:0]               count;
    sst_pkg::t_tok            res0, res1;
    logic [sst_pkg::TokBits:0] head;

    assign s_axis_tready = room2;
    assign take = s_axis_tvalid && room2;

    sst_scan #(.POS_BITS(POS_BITS), .KEYWORD_CHARS(KEYWORD_CHARS)) u_scan (
        .i_clk, .i_rst_n, .i_take(take), .i_op(s_axis_tuser), .i_byte(s_axis_tdata),
        .o_res0(res0), .o_res1(res1), .o_last0(last0), .o_count(count)
    );

    sst_fifo u_fifo (
        .i_clk, .i_rst_n, .i_push(count),
        .i_d0({last0, res0}), .i_d1({1'b1, res1}),
        .i_pop(m_axis_tready), .o_head(head), .o_valid(m_axis_tvalid), .o_room2(room2)
    );

    assign m_axis_tdata = {7'b0, head[sst_pkg::TokBits-1:0]};
    assign m_axis_tlast = head[sst_pkg::TokBits];

endmodule

`default_nettype wire
